[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the two-wire JTAG master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a boolean expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: assertion failed");
// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/jtm_pkg.sv]
// Types and constants of the two-wire four-phase JTAG master.
package jtm_pkg;

  localparam int DATA_BITS_DEF = 32;
  localparam int CMD_BITS_DEF  = 5;
  localparam int MODE_BITS_DEF = 6;

  // Bit index and segment length widths cover the whole parameter range (up to 64).
  localparam int BIT_IDX_W = 6;
  localparam int LEN_W     = BIT_IDX_W + 1;
  localparam int WORD_W    = 32;
  localparam int HPT_W     = 8;

  // TMS patterns, bit 0 is sent first.
  localparam logic [3:0] HDR_CMD_TMS  = 4'b0011;
  localparam logic [3:0] HDR_DATA_TMS = 4'b0001;
  localparam logic [1:0] FOOTER_TMS   = 2'b01;
  localparam int HDR_CMD_LEN  = 4;
  localparam int HDR_DATA_LEN = 3;
  localparam int FOOTER_LEN   = 2;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MODE = 3'd1,
    OP_CMD  = 3'd2,
    OP_DATA = 3'd3,
    OP_FAST = 3'd4
  } jtm_op_e;

  typedef enum logic [1:0] {
    SEG_HEADER = 2'd0,
    SEG_PRACC  = 2'd1,
    SEG_BODY   = 2'd2,
    SEG_FOOTER = 2'd3
  } jtm_seg_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [WORD_W-1:0] payload;
    logic              pgd_in;
  } jtm_in_t;

  typedef struct packed {
    logic              pgc;
    logic              pgd_out;
    logic              pgd_drive;
    logic              busy_res;
    logic              done_res;
    logic [WORD_W-1:0] read_data;
    logic              rejected;
  } jtm_out_t;

  typedef struct packed {
    jtm_op_e              op;
    jtm_seg_e             seg;
    logic [BIT_IDX_W-1:0] bit_index;
    logic [1:0]           phase;
    logic                 clock_high;
    logic [HPT_W-1:0]     tick_count;
    logic [WORD_W-1:0]    tdi_shift;
    logic [WORD_W-1:0]    tdo_shift;
    logic                 prefix_bit;
    logic [WORD_W-1:0]    result_word;
  } jtm_state_t;

  localparam jtm_state_t STATE_RESET = '{
    op:          OP_NONE,
    seg:         SEG_HEADER,
    bit_index:   '0,
    phase:       '0,
    clock_high:  1'b0,
    tick_count:  '0,
    tdi_shift:   '0,
    tdo_shift:   '0,
    prefix_bit:  1'b0,
    result_word: '0
  };

endpackage

[sv/jtm_core.sv]
// Next-state and line-level logic for one transaction of the JTAG master.
module jtm_core #(
  parameter int DATA_BITS = jtm_pkg::DATA_BITS_DEF,
  parameter int CMD_BITS  = jtm_pkg::CMD_BITS_DEF,
  parameter int MODE_BITS = jtm_pkg::MODE_BITS_DEF
) (
  input  jtm_pkg::jtm_state_t               state_i,
  input  jtm_pkg::jtm_in_t                  item_i,
  input  logic [jtm_pkg::HPT_W-1:0]         half_phase_ticks_i,
  output jtm_pkg::jtm_state_t               state_o,
  output jtm_pkg::jtm_out_t                 result_o
);
  import jtm_pkg::*;

  // Number of bits in a segment of a frame, zero when the frame skips it.
  function automatic logic [LEN_W-1:0] seg_len(jtm_op_e op, logic [2:0] seg);
    logic [LEN_W-1:0] len;
    len = '0;
    case (seg)
      3'd0: begin
        if (op == OP_CMD) len = LEN_W'(HDR_CMD_LEN);
        else if (op == OP_DATA || op == OP_FAST) len = LEN_W'(HDR_DATA_LEN);
      end
      3'd1: begin
        if (op == OP_FAST) len = LEN_W'(1);
      end
      3'd2: begin
        if (op == OP_MODE) len = LEN_W'(MODE_BITS);
        else if (op == OP_CMD) len = LEN_W'(CMD_BITS);
        else len = LEN_W'(DATA_BITS);
      end
      3'd3: begin
        if (op != OP_MODE && op != OP_NONE) len = LEN_W'(FOOTER_LEN);
      end
      default: len = '0;
    endcase
    return len;
  endfunction

  // First non-empty segment at or after a given one; four means the frame is over.
  function automatic logic [2:0] next_seg(jtm_op_e op, logic [2:0] from);
    logic [2:0] found;
    logic       hit;
    found = 3'd4;
    hit   = 1'b0;
    for (int s = 0; s < 4; s++) begin
      if (!hit && 3'(s) >= from && seg_len(op, 3'(s)) != '0) begin
        found = 3'(s);
        hit   = 1'b1;
      end
    end
    return found;
  endfunction

  jtm_state_t       st;
  logic             done;
  logic             rej;
  logic [HPT_W-1:0] hpt;
  logic [HPT_W:0]   tc_inc;
  logic [LEN_W-1:0] idx_inc;
  logic [2:0]       nseg;
  logic             busy;
  logic             in32;
  logic             body_bit;
  logic             tms;
  logic             tdi;

  assign hpt = (half_phase_ticks_i == '0) ? HPT_W'(1) : half_phase_ticks_i;

  always_comb begin
    st      = state_i;
    done    = 1'b0;
    rej     = 1'b0;
    tc_inc  = {1'b0, state_i.tick_count} + (HPT_W+1)'(1);
    idx_inc = {1'b0, state_i.bit_index} + LEN_W'(1);
    nseg    = {1'b0, state_i.seg};
    if (item_i.command != OP_NONE) begin
      if (state_i.op != OP_NONE) begin
        rej = 1'b1;
      end else if (item_i.command inside {[OP_MODE:OP_FAST]}) begin
        st.op         = jtm_op_e'(item_i.command);
        st.tdi_shift  = item_i.payload;
        st.tdo_shift  = '0;
        st.prefix_bit = 1'b0;
        st.seg        = jtm_seg_e'(next_seg(jtm_op_e'(item_i.command), 3'd0));
        st.bit_index  = '0;
        st.phase      = '0;
        st.clock_high = 1'b1;
        st.tick_count = '0;
      end
    end else if (state_i.op != OP_NONE) begin
      if (tc_inc >= {1'b0, hpt}) begin
        st.tick_count = '0;
        if (state_i.clock_high) begin
          st.clock_high = 1'b0;
        end else begin
          // TDO is sampled at the end of the low half of phase three.
          if (state_i.phase == 2'd2) begin
            if ((state_i.seg == SEG_HEADER && state_i.op == OP_DATA &&
                 state_i.bit_index == BIT_IDX_W'(HDR_DATA_LEN - 1)) ||
                state_i.seg == SEG_PRACC) begin
              st.prefix_bit = item_i.pgd_in;
            end else if (state_i.seg == SEG_BODY &&
                         (state_i.op == OP_DATA || state_i.op == OP_FAST)) begin
              for (int i = 0; i < WORD_W; i++) begin
                if (state_i.bit_index == BIT_IDX_W'(i)) begin
                  st.tdo_shift[i] = state_i.tdo_shift[i] | item_i.pgd_in;
                end
              end
            end
          end
          if (state_i.phase != 2'd3) begin
            st.phase = state_i.phase + 2'd1;
          end else begin
            st.phase = '0;
            if (idx_inc >= seg_len(state_i.op, {1'b0, state_i.seg})) begin
              st.bit_index = '0;
              nseg = next_seg(state_i.op, {1'b0, state_i.seg} + 3'd1);
            end else begin
              st.bit_index = idx_inc[BIT_IDX_W-1:0];
            end
          end
          if (nseg[2]) begin
            if (state_i.op == OP_DATA || state_i.op == OP_FAST) begin
              st.result_word = {st.tdo_shift[WORD_W-2:0], st.prefix_bit};
            end
            st.op        = OP_NONE;
            st.seg       = SEG_HEADER;
            st.bit_index = '0;
            st.phase     = '0;
            done         = 1'b1;
          end else begin
            st.seg        = jtm_seg_e'(nseg[1:0]);
            st.clock_high = 1'b1;
          end
        end
      end else begin
        st.tick_count = tc_inc[HPT_W-1:0];
      end
    end
  end

  // Line levels follow the state after this transaction.
  always_comb begin
    busy     = st.op != OP_NONE;
    in32     = st.bit_index < BIT_IDX_W'(WORD_W);
    body_bit = st.tdi_shift[st.bit_index[$clog2(WORD_W)-1:0]] & in32;
    tms      = 1'b0;
    case (st.seg)
      SEG_HEADER: begin
        if (st.bit_index < BIT_IDX_W'(4)) begin
          tms = (st.op == OP_CMD) ? HDR_CMD_TMS[st.bit_index[1:0]]
                                  : HDR_DATA_TMS[st.bit_index[1:0]];
        end
      end
      SEG_BODY: begin
        if (st.op == OP_MODE) tms = body_bit;
        else tms = ({1'b0, st.bit_index} + LEN_W'(1)) == seg_len(st.op, 3'd2);
      end
      SEG_FOOTER: begin
        if (st.bit_index < BIT_IDX_W'(FOOTER_LEN)) tms = FOOTER_TMS[st.bit_index[0]];
      end
      default: tms = 1'b0;
    endcase
    tdi = (st.seg == SEG_BODY && st.op != OP_MODE) ? body_bit : 1'b0;

    result_o.pgc = busy & st.clock_high;
    if (!busy) begin
      result_o.pgd_out   = 1'b0;
      result_o.pgd_drive = 1'b1;
    end else if (st.phase < 2'd2) begin
      result_o.pgd_out   = (st.phase == 2'd0) ? tdi : tms;
      result_o.pgd_drive = 1'b1;
    end else begin
      result_o.pgd_out   = 1'b0;
      result_o.pgd_drive = 1'b0;
    end
    result_o.busy_res  = busy;
    result_o.done_res  = done;
    result_o.read_data = st.result_word;
    result_o.rejected  = rej;
  end

  assign state_o = st;

endmodule

[sv/two_wire_four_phase_jtag_master.sv]
// Top level of the two-wire four-phase JTAG master with its handshake registers.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_ready_o  jtm_in_t: command, payload, pgd_in
//   out       output     out_valid_o/out_ready_i jtm_out_t: line levels and status
//   cfg       input      cfg_valid_i/cfg_ready_o half_phase_ticks (8 bits)
//
// Every transaction, a tick or a command, goes through combinational logic: the
// frame state register feeds the step logic, and the result lands in the output
// register at the same edge. A new transaction is taken every cycle as long as
// the output register is empty or is being emptied in that cycle.
// Reset (rst_ni low) clears the frame state, empties the output register and
// sets half_phase_ticks to one. The configuration channel is always ready.
module two_wire_four_phase_jtag_master #(
  parameter int DATA_BITS = jtm_pkg::DATA_BITS_DEF,
  parameter int CMD_BITS  = jtm_pkg::CMD_BITS_DEF,
  parameter int MODE_BITS = jtm_pkg::MODE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  jtm_pkg::jtm_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output jtm_pkg::jtm_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [jtm_pkg::HPT_W-1:0] cfg_data_i
);
  import jtm_pkg::*;
  `include "assert_macros.svh"

  jtm_state_t       state_q;
  jtm_state_t       state_d;
  jtm_out_t         result_d;
  jtm_out_t         out_data_q;
  logic             out_valid_q;
  logic [HPT_W-1:0] hpt_q;
  logic             in_fire;

  // The output register acts as the skid stage: a waiting result only blocks
  // the input side when the consumer is not taking it in this cycle.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  jtm_core #(
    .DATA_BITS (DATA_BITS),
    .CMD_BITS  (CMD_BITS),
    .MODE_BITS (MODE_BITS)
  ) u_core (
    .state_i            (state_q),
    .item_i             (in_data_i),
    .half_phase_ticks_i (hpt_q),
    .state_o            (state_d),
    .result_o           (result_d)
  );

  // Frame state only moves when a transaction is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpt_q <= HPT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      hpt_q <= cfg_data_i;
    end
  end

  // An idle master holds a clean frame position with the clock low.
  `ASSERT_ALWAYS(a_idle_clean, clk_i, rst_ni,
                 state_q.op != OP_NONE || (state_q.seg == SEG_HEADER &&
                 state_q.phase == 2'd0 && state_q.bit_index == '0 && !state_q.clock_high))
  // A completed transfer never reports busy and never leaves the clock high.
  `ASSERT_ALWAYS(a_done_not_busy, clk_i, rst_ni,
                 !(out_valid_q && out_data_q.done_res) ||
                 (!out_data_q.busy_res && !out_data_q.pgc))
  // A command that arrives during a transfer leaves the frame state untouched.
  `ASSERT_NEXT(a_reject_stable, clk_i, rst_ni,
               in_fire && state_q.op != OP_NONE && in_data_i.command != OP_NONE,
               $stable(state_q) && out_data_q.rejected)

endmodule

[sim/tb_two_wire_four_phase_jtag_master.sv]
// Self-checking testbench for the two-wire four-phase JTAG master.
module tb_two_wire_four_phase_jtag_master;
  import jtm_pkg::*;

  // Command codes above OP_FAST are not defined. An idle block ignores them,
  // and a busy block turns them away like any other command.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  // The receiver stops taking results for a long stretch once, at this result.
  localparam int unsigned HOLD_AT_RESULT = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  // Cycles without any transaction on any channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT    = 5000;
  // Items queued before the slow-setting tail; the random part stops once past it.
  localparam int unsigned ITEM_BUDGET    = 950;
  // Ticks run at the slowest setting, enough for the first clock half to run out.
  localparam int unsigned TAIL_TICKS     = 262;
  // Only the first mismatches are printed, so a broken block cannot flood the log.
  localparam int unsigned MAX_REPORTS    = 30;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  jtm_in_t   in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  jtm_out_t  out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [HPT_W-1:0] cfg_data_i = '0;

  two_wire_four_phase_jtag_master i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stimulus waiting to be offered, expected line states waiting to be seen,
  // and configuration writes waiting to be sent.
  jtm_in_t          pending_items[$];
  jtm_out_t         expected_lines[$];
  logic [HPT_W-1:0] cfg_writes[$];

  // Predicted frame state and the half-phase setting that the block holds.
  jtm_state_t       frame_now   = STATE_RESET;
  logic [HPT_W-1:0] half_ticks  = 8'd1;
  // The setting as the stimulus generator plans with it.
  logic [HPT_W-1:0] plan_hpt    = 8'd1;

  // During calm stretches neither side inserts random gaps.
  logic        calm = 1'b0;
  int unsigned tx_gap;
  int unsigned rx_hold;
  int unsigned rx_count;
  logic        tx_fire;
  int unsigned quiet_cycles;

  int unsigned stim_count;
  int unsigned items_taken;
  int unsigned cfg_taken;
  int unsigned mismatches;
  int unsigned rejects_seen;
  int unsigned frames_done[5];
  jtm_out_t    want_line;

  function automatic int unsigned draw_gap();
    int unsigned g;
    g = $urandom_range(0, 16);
    return calm ? 0 : g;
  endfunction

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Number of bits in one segment of a frame; zero means the segment is skipped.
  function automatic int unsigned seg_bits(jtm_op_e op, int unsigned s);
    case (s)
      SEG_HEADER: return (op == OP_CMD) ? HDR_CMD_LEN : ((op >= OP_DATA) ? HDR_DATA_LEN : 0);
      SEG_PRACC:  return (op == OP_FAST) ? 1 : 0;
      SEG_BODY:   return (op == OP_MODE) ? MODE_BITS_DEF :
                         ((op == OP_CMD) ? CMD_BITS_DEF : DATA_BITS_DEF);
      SEG_FOOTER: return (op >= OP_CMD) ? FOOTER_LEN : 0;
      default:    return 0;
    endcase
  endfunction

  // First segment at or after 'from' that the operation uses; 4 when none is left.
  function automatic int unsigned seek_seg(jtm_op_e op, int unsigned from);
    for (int unsigned s = from; s < 4; s++) begin
      if (seg_bits(op, s) != 0) return s;
    end
    return 4;
  endfunction

  function automatic logic pick(logic [31:0] w, int unsigned i);
    return (i < 32) ? w[i] : 1'b0;
  endfunction

  function automatic logic tms_now();
    case (frame_now.seg)
      SEG_HEADER: return pick((frame_now.op == OP_CMD) ? 32'(HDR_CMD_TMS) : 32'(HDR_DATA_TMS),
                              frame_now.bit_index);
      SEG_BODY: begin
        if (frame_now.op == OP_MODE) return pick(frame_now.tdi_shift, frame_now.bit_index);
        return (frame_now.bit_index + 1 == seg_bits(frame_now.op, SEG_BODY));
      end
      SEG_FOOTER: return pick(32'(FOOTER_TMS), frame_now.bit_index);
      default:    return 1'b0;
    endcase
  endfunction

  // TDI carries payload bits only in the body of a command, data or fast frame.
  function automatic logic tdi_now();
    if (frame_now.seg == SEG_BODY && frame_now.op != OP_MODE)
      return pick(frame_now.tdi_shift, frame_now.bit_index);
    return 1'b0;
  endfunction

  // TDO sampled at the end of phase three: the last data header bit and the
  // PrAcc bit set the prefix, body bits of data and fast frames fill the read shifter.
  function automatic void grab_tdo(logic tdo);
    if (frame_now.seg == SEG_HEADER && frame_now.op == OP_DATA &&
        frame_now.bit_index + 1 == HDR_DATA_LEN)
      frame_now.prefix_bit = tdo;
    else if (frame_now.seg == SEG_PRACC)
      frame_now.prefix_bit = tdo;
    else if (frame_now.seg == SEG_BODY && frame_now.op >= OP_DATA && frame_now.bit_index < 32)
      frame_now.tdo_shift = frame_now.tdo_shift | (32'(tdo) << frame_now.bit_index);
  endfunction

  // Advances the predicted frame by one transaction and returns the line
  // state that the block must report for it.
  function automatic jtm_out_t predict_line_step(jtm_in_t it);
    jtm_out_t    r;
    logic        fin;
    logic        rej;
    logic        busy;
    int unsigned nxt;
    int unsigned lim;
    fin = 1'b0;
    rej = 1'b0;
    if (it.command != OP_NONE) begin
      if (frame_now.op != OP_NONE) begin
        rej = 1'b1;
      end else if (it.command <= OP_FAST) begin
        frame_now.op         = jtm_op_e'(it.command);
        frame_now.tdi_shift  = it.payload;
        frame_now.tdo_shift  = '0;
        frame_now.prefix_bit = 1'b0;
        frame_now.seg        = jtm_seg_e'(seek_seg(frame_now.op, 0));
        frame_now.bit_index  = '0;
        frame_now.phase      = '0;
        frame_now.clock_high = 1'b1;
        frame_now.tick_count = '0;
      end
    end else if (frame_now.op != OP_NONE) begin
      lim = (half_ticks == 0) ? 1 : half_ticks;
      frame_now.tick_count = frame_now.tick_count + 1'b1;
      if (frame_now.tick_count >= lim) begin
        frame_now.tick_count = '0;
        if (frame_now.clock_high) begin
          frame_now.clock_high = 1'b0;
        end else begin
          nxt = frame_now.seg;
          if (frame_now.phase == 2'd2) grab_tdo(it.pgd_in);
          if (frame_now.phase < 2'd3) begin
            frame_now.phase = frame_now.phase + 1'b1;
          end else begin
            frame_now.phase     = '0;
            frame_now.bit_index = frame_now.bit_index + 1'b1;
            if (frame_now.bit_index >= seg_bits(frame_now.op, frame_now.seg)) begin
              frame_now.bit_index = '0;
              nxt = seek_seg(frame_now.op, frame_now.seg + 1);
            end
          end
          if (nxt > SEG_FOOTER) begin
            if (frame_now.op >= OP_DATA)
              frame_now.result_word = {frame_now.tdo_shift[30:0], frame_now.prefix_bit};
            frames_done[frame_now.op]++;
            frame_now.op        = OP_NONE;
            frame_now.seg       = SEG_HEADER;
            frame_now.bit_index = '0;
            frame_now.phase     = '0;
            fin = 1'b1;
          end else begin
            frame_now.seg        = jtm_seg_e'(nxt);
            frame_now.clock_high = 1'b1;
          end
        end
      end
    end

    busy = (frame_now.op != OP_NONE);
    r = '0;
    r.pgc = busy & frame_now.clock_high;
    if (!busy) begin
      // An idle master holds the data line low.
      r.pgd_drive = 1'b1;
    end else if (frame_now.phase < 2'd2) begin
      r.pgd_out   = (frame_now.phase == 2'd0) ? tdi_now() : tms_now();
      r.pgd_drive = 1'b1;
    end
    r.busy_res  = busy;
    r.done_res  = fin;
    r.read_data = frame_now.result_word;
    r.rejected  = rej;
    if (rej) rejects_seen++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, predicts each one when its transaction happens.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_gap      = 0;
    end else begin
      tx_fire = in_valid_i && in_ready_o;
      if (tx_fire) begin
        expected_lines.push_back(predict_line_step(in_data_i));
        items_taken++;
      end
      // Valid drops only after a transaction or while idle, and is assigned
      // once per edge so a back-to-back item keeps it high.
      if (!in_valid_i || tx_fire) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          tx_gap      = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Configuration writes; the predictor takes the new setting with the transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      cfg_data_i  <= '0;
      half_ticks   = 8'd1;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        half_ticks = cfg_data_i;
        cfg_taken++;
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (cfg_writes.size() != 0) begin
          cfg_data_i  <= cfg_writes.pop_front();
          cfg_valid_i <= 1'b1;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall after each result, plus one long hold-off that
  // lets the output register fill so the block must stall its input side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold      = 0;
      rx_count     = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        rx_count++;
        rx_hold = (rx_count == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_gap();
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      out_ready_i <= (rx_hold == 0);
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Monitor: every result is matched against the oldest expected line state.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, out_data_o);
      end else begin
        want_line = expected_lines.pop_front();
        check_field("pgc",       32'(want_line.pgc),       32'(out_data_o.pgc));
        check_field("pgd_out",   32'(want_line.pgd_out),   32'(out_data_o.pgd_out));
        check_field("pgd_drive", 32'(want_line.pgd_drive), 32'(out_data_o.pgd_drive));
        check_field("busy_res",  32'(want_line.busy_res),  32'(out_data_o.busy_res));
        check_field("done_res",  32'(want_line.done_res),  32'(out_data_o.done_res));
        check_field("read_data", want_line.read_data,      out_data_o.read_data);
        check_field("rejected",  32'(want_line.rejected),  32'(out_data_o.rejected));
      end
    end
  end

  // Watchdog: a run in which no channel moves for too long is hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still expected",
               $time, QUIET_LIMIT, expected_lines.size());
      $display("two_wire_four_phase_jtag_master test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic push_item(input logic [2:0] cmd, input logic [31:0] word, input logic pin);
    jtm_in_t it;
    it.command = cmd;
    it.payload = word;
    it.pgd_in  = pin;
    pending_items.push_back(it);
    stim_count++;
  endtask

  // Ticks that clock out a frame of 'op' at the planned half-phase setting:
  // every bit is four phases of a high and a low half.
  function automatic int unsigned frame_ticks(jtm_op_e op);
    int unsigned bits;
    bits = 0;
    for (int unsigned s = 0; s < 4; s++) bits += seg_bits(op, s);
    return bits * 8 * ((plan_hpt == 0) ? 1 : plan_hpt);
  endfunction

  // pin_sel: 0 line low, 1 line high, 2 random level on each tick.
  // noise_pct: chance of a stray command ahead of each tick.
  task automatic queue_ticks(input int unsigned n, input int pin_sel, input int unsigned noise_pct);
    logic pin;
    for (int unsigned k = 0; k < n; k++) begin
      if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
        push_item(3'($urandom_range(1, 7)), $urandom, 1'($urandom));
      pin = (pin_sel == 2) ? 1'($urandom) : (pin_sel == 1);
      push_item(OP_NONE, $urandom, pin);
    end
  endtask

  task automatic queue_frame(input jtm_op_e op, input logic [31:0] word, input int pin_sel,
                             input int unsigned noise_pct);
    push_item(op, word, 1'($urandom));
    queue_ticks(frame_ticks(op), pin_sel, noise_pct);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_lines.size() != 0);
  endtask

  // The setting changes only with no frame running and nothing in flight.
  task automatic write_cfg(input logic [HPT_W-1:0] value);
    wait_drained();
    while (frame_now.op != OP_NONE) begin
      queue_ticks(16, 2, 0);
      wait_drained();
    end
    repeat (2) @(negedge clk_i);
    cfg_writes.push_back(value);
    do @(negedge clk_i);
    while (cfg_writes.size() != 0 || cfg_valid_i);
    plan_hpt = value;
  endtask

  initial begin
    logic [31:0] word;
    jtm_op_e     op;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset setting: idle ticks, spare codes while idle,
    // commands turned away during a frame, and frames with extreme payloads
    // and constant data line levels.
    push_item(OP_NONE, '0, 1'b0);
    push_item(OP_NONE, '1, 1'b1);
    push_item(CMD_SPARE_FIRST, '1, 1'b1);
    push_item(CMD_SPARE_FIRST + 3'd1, '0, 1'b0);
    push_item(CMD_SPARE_LAST, 32'h5A5A_A5A5, 1'b1);
    push_item(OP_MODE, '1, 1'b0);
    push_item(OP_DATA, 32'h1234_5678, 1'b1);
    push_item(CMD_SPARE_LAST, '1, 1'b0);
    push_item(OP_MODE, '0, 1'b1);
    queue_ticks(frame_ticks(OP_MODE), 1, 0);
    queue_frame(OP_CMD, 32'h0000_001F, 0, 0);
    queue_frame(OP_DATA, '1, 1, 0);
    // A command frame after a data frame must leave the read word alone.
    queue_frame(OP_CMD, '0, 2, 0);
    queue_frame(OP_FAST, '0, 0, 0);
    push_item(OP_NONE, $urandom, 1'b1);

    // Zero half phase behaves like one tick per half.
    write_cfg(8'd0);
    queue_frame(OP_MODE, $urandom, 2, 5);

    // Random part: small settings, well-formed frames with random content,
    // stray commands while busy and junk while idle.
    while (stim_count < ITEM_BUDGET) begin
      case ($urandom_range(0, 3))
        0:       write_cfg(8'd0);
        3:       write_cfg(8'd2);
        default: write_cfg(8'd1);
      endcase
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1) == 0)
          push_item(OP_NONE, $urandom, 1'($urandom));
        else
          push_item(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), $urandom, 1'($urandom));
      end
      op = jtm_op_e'($urandom_range(OP_MODE, OP_FAST));
      case ($urandom_range(0, 7))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      queue_frame(op, word, 2, 4);
    end

    // Slowest setting at the end: a frame starts and its first clock half
    // runs out, but the run stops before the frame completes.
    write_cfg(8'd255);
    calm = 1'b1;
    push_item(OP_MODE, $urandom, 1'b0);
    queue_ticks(TAIL_TICKS, 2, 0);

    wait_drained();
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d transactions and %0d setting changes, last setting %0d.",
             items_taken, cfg_taken, half_ticks);
    $display("Frames done: %0d mode, %0d command, %0d data, %0d fast; %0d commands refused.",
             frames_done[OP_MODE], frames_done[OP_CMD], frames_done[OP_DATA],
             frames_done[OP_FAST], rejects_seen);
    if (mismatches == 0)
      $display("two_wire_four_phase_jtag_master test passed");
    else
      $display("two_wire_four_phase_jtag_master test failed");
    $finish;
  end

endmodule
